// ===== hw/rtl/sws_pkg.sv =====
// Shared types and constants for the text word and sentence statistics block.
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;

   // Field widths
   localparam int BYTE_W        = 8;
   localparam int WORD_LEN_W    = 6;
   localparam int SENT_WORDS_W  = 8;
   localparam int OUT_COUNT_W   = 20;
   localparam int RATIO_W       = 24;
   localparam int FRAC_BITS     = 16;
   localparam int NUM_COUNTERS  = 8;

   // Configuration port
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHORT_WORD_MAX       = 2'd0,
      CSR_LONG_WORD_MIN        = 2'd1,
      CSR_SHORT_SENTENCE_BELOW = 2'd2,
      CSR_LONG_SENTENCE_MIN    = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic [WORD_LEN_W-1:0]   RST_SHORT_WORD_MAX       = 6'd4;
   localparam logic [WORD_LEN_W-1:0]   RST_LONG_WORD_MIN        = 6'd9;
   localparam logic [SENT_WORDS_W-1:0] RST_SHORT_SENTENCE_BELOW = 8'd10;
   localparam logic [SENT_WORDS_W-1:0] RST_LONG_SENTENCE_MIN    = 8'd20;

   // Saturation limits
   localparam logic [WORD_LEN_W-1:0]   WORD_LEN_MAX   = 6'd63;
   localparam logic [SENT_WORDS_W-1:0] SENT_WORDS_MAX = 8'd255;
   localparam logic [OUT_COUNT_W-1:0]  OUT_COUNT_MAX  = 20'hFFFFF;
   localparam logic [RATIO_W-1:0]      RATIO_MAX      = 24'hFFFFFF;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_PERIOD   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_BANG     = 8'h21;
   localparam logic [BYTE_W-1:0] CH_DIGIT_LO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_DIGIT_HI = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UPPER_LO = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_HI = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_LO = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_HI = 8'h7A;

   // Event queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_FILL_W = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_W-1:0] word_total;
      logic [OUT_COUNT_W-1:0] short_word_total;
      logic [OUT_COUNT_W-1:0] medium_word_total;
      logic [OUT_COUNT_W-1:0] long_word_total;
      logic [OUT_COUNT_W-1:0] sentence_total;
      logic [OUT_COUNT_W-1:0] short_sentence_total;
      logic [OUT_COUNT_W-1:0] medium_sentence_total;
      logic [OUT_COUNT_W-1:0] long_sentence_total;
      logic [RATIO_W-1:0]     sentence_word_ratio;
      logic                   ratio_invalid;
   } rsp_type;

   // Classified byte handed from front to back
   typedef struct packed {
      logic alnum;
      logic space;
      logic term;
      logic quote;
      logic last;
   } event_type;

   typedef struct packed {
      logic [WORD_LEN_W-1:0]   short_word_max;
      logic [WORD_LEN_W-1:0]   long_word_min;
      logic [SENT_WORDS_W-1:0] short_sentence_below;
      logic [SENT_WORDS_W-1:0] long_sentence_min;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sws_front.sv =====
// Front end: classifies each text byte and queues the event for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sws_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sws_pkg::req_type   req_data,
   output logic                    evt_valid,
   output sws_pkg::event_type      evt_data,
   input  wire logic               evt_take
);

   sws_pkg::event_type                 evt_new;
   sws_pkg::event_type                 queue_ff [sws_pkg::QUEUE_DEPTH];
   logic [sws_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [sws_pkg::QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [sws_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [sws_pkg::QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [sws_pkg::QUEUE_FILL_W-1:0]   fill_ff;
   logic [sws_pkg::QUEUE_FILL_W-1:0]   fill_in;
   logic                               push;
   logic                               pop;
   logic [sws_pkg::BYTE_W-1:0]         b;

   // Classify the incoming byte
   always_comb begin
      b = req_data.text_byte;
      evt_new.alnum = (b >= sws_pkg::CH_DIGIT_LO && b <= sws_pkg::CH_DIGIT_HI) ||
                      (b >= sws_pkg::CH_UPPER_LO && b <= sws_pkg::CH_UPPER_HI) ||
                      (b >= sws_pkg::CH_LOWER_LO && b <= sws_pkg::CH_LOWER_HI);
      evt_new.space = (b == sws_pkg::CH_SPACE);
      evt_new.quote = (b == sws_pkg::CH_QUOTE);
      evt_new.term  = (b == sws_pkg::CH_PERIOD) || (b == sws_pkg::CH_QUESTION) ||
                      (b == sws_pkg::CH_BANG);
      evt_new.last  = req_data.end_of_text;
   end

   // Queue control: stall only when full
   assign req_stall = (fill_ff == sws_pkg::QUEUE_FILL_W'(sws_pkg::QUEUE_DEPTH));
   assign evt_valid = (fill_ff != '0);
   assign evt_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = evt_take && evt_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the transfer's event
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= evt_new;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sws_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sws_div #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W-1:0]  dvs_in;
   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Shift in one dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sws_back.sv =====
// Back end: word and sentence tracking, counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module sws_back #(
   parameter int COUNT_WIDTH = 20
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       csr_we,
   input  wire logic [sws_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [sws_pkg::CSR_DATA_W-1:0]             csr_wdata,
   input  wire logic                                       evt_valid,
   input  wire sws_pkg::event_type                         evt_data,
   output logic                                            evt_take,
   output logic                                            div_start,
   output logic [COUNT_WIDTH+sws_pkg::FRAC_BITS-1:0]       div_dividend,
   output logic [COUNT_WIDTH-1:0]                          div_divisor,
   input  wire logic                                       div_done,
   input  wire logic [COUNT_WIDTH+sws_pkg::FRAC_BITS-1:0]  div_quotient,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output sws_pkg::rsp_type                                rsp_data
);

   localparam int CNT_WORD      = 0;
   localparam int CNT_WORD_S    = 1;
   localparam int CNT_WORD_M    = 2;
   localparam int CNT_WORD_L    = 3;
   localparam int CNT_SENT      = 4;
   localparam int CNT_SENT_S    = 5;
   localparam int CNT_SENT_M    = 6;
   localparam int CNT_SENT_L    = 7;

   typedef enum logic [2:0] {
      ST_RUN    = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_SEND   = 3'b100
   } back_state_type;

   back_state_type                         state_ff;
   back_state_type                         state_in;
   sws_pkg::cfg_type                       cfg_ff;
   sws_pkg::cfg_type                       cfg_in;
   logic [sws_pkg::WORD_LEN_W-1:0]         wl_ff;
   logic [sws_pkg::WORD_LEN_W-1:0]         wl_in;
   logic [sws_pkg::SENT_WORDS_W-1:0]       sw_ff;
   logic [sws_pkg::SENT_WORDS_W-1:0]       sw_in;
   logic                                   pend_ff;
   logic                                   pend_in;
   logic [COUNT_WIDTH-1:0]                 cnt_ff [sws_pkg::NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]                 cnt_in [sws_pkg::NUM_COUNTERS];
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   sws_pkg::rsp_type                       rsp_data_ff;
   sws_pkg::rsp_type                       rsp_data_in;
   logic                                   close_s_pre;
   logic                                   close_s_post;
   logic                                   close_w;
   logic [sws_pkg::SENT_WORDS_W-1:0]       sw_cleared;
   logic [sws_pkg::SENT_WORDS_W-1:0]       sw_after_word;
   logic [sws_pkg::SENT_WORDS_W-1:0]       sent_len;
   logic [63:0]                            quo_wide;

   function automatic logic [COUNT_WIDTH-1:0] bump_count(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

   function automatic logic [sws_pkg::OUT_COUNT_W-1:0] clamp_count(
         input logic [COUNT_WIDTH-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return (w > 32'(sws_pkg::OUT_COUNT_MAX)) ? sws_pkg::OUT_COUNT_MAX : w[19:0];
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sws_pkg::csr_index_type'(csr_index))
            sws_pkg::CSR_SHORT_WORD_MAX: begin
               cfg_in.short_word_max = csr_wdata[sws_pkg::WORD_LEN_W-1:0];
            end
            sws_pkg::CSR_LONG_WORD_MIN: begin
               cfg_in.long_word_min = csr_wdata[sws_pkg::WORD_LEN_W-1:0];
            end
            sws_pkg::CSR_SHORT_SENTENCE_BELOW: begin
               cfg_in.short_sentence_below = csr_wdata;
            end
            sws_pkg::CSR_LONG_SENTENCE_MIN: begin
               cfg_in.long_sentence_min = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Resolve a pending terminator, then this byte's word and sentence handling
   always_comb begin
      close_s_pre   = pend_ff && (evt_data.space || evt_data.quote);
      close_w       = (evt_data.term || evt_data.space) && (wl_ff != '0);
      sw_cleared    = close_s_pre ? '0 : sw_ff;
      sw_after_word = (close_w && sw_cleared != sws_pkg::SENT_WORDS_MAX) ?
                      sw_cleared + 1'b1 : sw_cleared;
      close_s_post  = evt_data.term && evt_data.last;
      sent_len      = close_s_pre ? sw_ff : sw_after_word;
   end

   // Sequencer: run events, divide at end of text, send the result
   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      sw_in        = sw_ff;
      pend_in      = pend_ff;
      cnt_in       = cnt_ff;
      evt_take     = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      quo_wide     = 64'(div_quotient);

      // Drop the result once it is transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_RUN: begin
            if (evt_valid) begin
               evt_take = 1'b1;
               if (close_w) begin
                  cnt_in[CNT_WORD] = bump_count(cnt_ff[CNT_WORD]);
                  if (wl_ff <= cfg_ff.short_word_max) begin
                     cnt_in[CNT_WORD_S] = bump_count(cnt_ff[CNT_WORD_S]);
                  end else if (wl_ff < cfg_ff.long_word_min) begin
                     cnt_in[CNT_WORD_M] = bump_count(cnt_ff[CNT_WORD_M]);
                  end else begin
                     cnt_in[CNT_WORD_L] = bump_count(cnt_ff[CNT_WORD_L]);
                  end
                  wl_in = '0;
               end else if (evt_data.alnum && wl_ff != sws_pkg::WORD_LEN_MAX) begin
                  wl_in = wl_ff + 1'b1;
               end
               if (close_s_pre || close_s_post) begin
                  cnt_in[CNT_SENT] = bump_count(cnt_ff[CNT_SENT]);
                  if (sent_len < cfg_ff.short_sentence_below) begin
                     cnt_in[CNT_SENT_S] = bump_count(cnt_ff[CNT_SENT_S]);
                  end else if (sent_len < cfg_ff.long_sentence_min) begin
                     cnt_in[CNT_SENT_M] = bump_count(cnt_ff[CNT_SENT_M]);
                  end else begin
                     cnt_in[CNT_SENT_L] = bump_count(cnt_ff[CNT_SENT_L]);
                  end
               end
               sw_in   = close_s_post ? '0 : sw_after_word;
               pend_in = evt_data.term && !evt_data.last;
               if (evt_data.last) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                      = 1'b1;
               rsp_data_in.word_total            = clamp_count(cnt_ff[CNT_WORD]);
               rsp_data_in.short_word_total      = clamp_count(cnt_ff[CNT_WORD_S]);
               rsp_data_in.medium_word_total     = clamp_count(cnt_ff[CNT_WORD_M]);
               rsp_data_in.long_word_total       = clamp_count(cnt_ff[CNT_WORD_L]);
               rsp_data_in.sentence_total        = clamp_count(cnt_ff[CNT_SENT]);
               rsp_data_in.short_sentence_total  = clamp_count(cnt_ff[CNT_SENT_S]);
               rsp_data_in.medium_sentence_total = clamp_count(cnt_ff[CNT_SENT_M]);
               rsp_data_in.long_sentence_total   = clamp_count(cnt_ff[CNT_SENT_L]);
               if (cnt_ff[CNT_WORD] == '0) begin
                  rsp_data_in.sentence_word_ratio = '0;
                  rsp_data_in.ratio_invalid       = 1'b1;
               end else begin
                  rsp_data_in.sentence_word_ratio =
                     (quo_wide > 64'(sws_pkg::RATIO_MAX)) ? sws_pkg::RATIO_MAX :
                     quo_wide[sws_pkg::RATIO_W-1:0];
                  rsp_data_in.ratio_invalid       = 1'b0;
               end
               // Clear the text state for the next text
               for (int i = 0; i < sws_pkg::NUM_COUNTERS; i++) begin
                  cnt_in[i] = '0;
               end
               wl_in    = '0;
               sw_in    = '0;
               pend_in  = 1'b0;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // Divider operands come from the counts after the final byte
      div_dividend = {cnt_in[CNT_SENT], {sws_pkg::FRAC_BITS{1'b0}}};
      div_divisor  = cnt_in[CNT_WORD];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                    <= ST_RUN;
         cfg_ff.short_word_max       <= sws_pkg::RST_SHORT_WORD_MAX;
         cfg_ff.long_word_min        <= sws_pkg::RST_LONG_WORD_MIN;
         cfg_ff.short_sentence_below <= sws_pkg::RST_SHORT_SENTENCE_BELOW;
         cfg_ff.long_sentence_min    <= sws_pkg::RST_LONG_SENTENCE_MIN;
         wl_ff                       <= '0;
         sw_ff                       <= '0;
         pend_ff                     <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         for (int i = 0; i < sws_pkg::NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         wl_ff        <= wl_in;
         sw_ff        <= sw_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < sws_pkg::NUM_COUNTERS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/text_word_sentence_stats_top.sv =====
// Top level of the text word and sentence statistics block.
//
// Usage:
//   req channel: one text byte per transfer, end_of_text set on the last byte.
//   rsp channel: one result per text (eight counts, sentence/word ratio in
//   unsigned Q8.16, ratio_invalid when no word was seen).
//   csr port: write-only, register index 0..3, taken whenever csr_we is high;
//   write only while no text is in flight.
// Throughput: one byte per cycle while a text streams, unless req_stall holds it.
//   The byte with end_of_text starts a bit-serial divide; the back end takes no
//   further bytes until the result is loaded, and the four-entry event queue
//   keeps accepting bytes of the next text meanwhile until it fills.
// Reset: synchronous, clears counters, queue and result; registers return to
//   their defaults. After each result the counters clear for the next text.
// Stall: a stalled result holds in the output register; the next result
//   waits for it, and req_stall rises once the event queue fills.
`timescale 1ns / 1ps
`default_nettype none
module text_word_sentence_stats_top #(
   parameter int COUNT_WIDTH = 20
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire sws_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output sws_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [sws_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sws_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int QUO_W = COUNT_WIDTH + sws_pkg::FRAC_BITS;

   logic                   evt_valid;
   sws_pkg::event_type     evt_data;
   logic                   evt_take;
   logic                   div_start;
   logic [QUO_W-1:0]       div_dividend;
   logic [COUNT_WIDTH-1:0] div_divisor;
   logic                   div_done;
   logic [QUO_W-1:0]       div_quotient;

   sws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .evt_valid (evt_valid),
      .evt_data  (evt_data),
      .evt_take  (evt_take)
   );

   sws_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .evt_valid    (evt_valid),
      .evt_data     (evt_data),
      .evt_take     (evt_take),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   sws_div #(
      .DIVIDEND_W (QUO_W),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/sws_check.sv =====
// Port-level checker for the statistics block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sws_check (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sws_pkg::rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // No result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Invalid ratio goes with no words and a zero ratio
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ratio_invalid == (rsp_data.word_total == '0)) &&
                    (!rsp_data.ratio_invalid || rsp_data.sentence_word_ratio == '0))
      else $error("ratio flag does not match word total");

   // Bin counts never exceed their totals
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.short_word_total <= rsp_data.word_total &&
                    rsp_data.medium_word_total <= rsp_data.word_total &&
                    rsp_data.long_word_total <= rsp_data.word_total &&
                    rsp_data.short_sentence_total <= rsp_data.sentence_total &&
                    rsp_data.medium_sentence_total <= rsp_data.sentence_total &&
                    rsp_data.long_sentence_total <= rsp_data.sentence_total)
      else $error("bin count above total");

endmodule

bind text_word_sentence_stats_top sws_check u_sws_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== tb/text_stats_checker.sv =====
// Checker for the text statistics block: tracks every byte transfer, predicts results, compares.
`timescale 1ns / 1ps
module text_stats_checker #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  sws_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  sws_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sws_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sws_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               mismatches,
   output int                               results_pending
);
   import sws_pkg::*;

   // Slots of the running tallies, in result order
   localparam int T_WORDS            = 0;
   localparam int T_SHORT_WORDS      = 1;
   localparam int T_MEDIUM_WORDS     = 2;
   localparam int T_LONG_WORDS       = 3;
   localparam int T_SENTENCES        = 4;
   localparam int T_SHORT_SENTENCES  = 5;
   localparam int T_MEDIUM_SENTENCES = 6;
   localparam int T_LONG_SENTENCES   = 7;

   cfg_type                  limits;
   logic [WORD_LEN_W-1:0]    word_len;
   logic [SENT_WORDS_W-1:0]  sent_words;
   logic                     term_pending;
   logic [COUNT_WIDTH-1:0]   tallies [NUM_COUNTERS];
   rsp_type                  text_stats_q [$];

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   task automatic bump(input int slot);
      if (tallies[slot] != {COUNT_WIDTH{1'b1}})
         tallies[slot] = tallies[slot] + 1'b1;
   endtask

   task automatic clear_text();
      word_len = '0;
      sent_words = '0;
      term_pending = 1'b0;
      foreach (tallies[i])
         tallies[i] = '0;
   endtask

   // Bin the finished word by length; short wins, then medium, else long
   task automatic close_word();
      bump(T_WORDS);
      if (word_len <= limits.short_word_max)
         bump(T_SHORT_WORDS);
      else if (word_len < limits.long_word_min)
         bump(T_MEDIUM_WORDS);
      else
         bump(T_LONG_WORDS);
      if (sent_words != SENT_WORDS_MAX)
         sent_words = sent_words + 1'b1;
      word_len = '0;
   endtask

   task automatic close_sentence();
      bump(T_SENTENCES);
      if (sent_words < limits.short_sentence_below)
         bump(T_SHORT_SENTENCES);
      else if (sent_words < limits.long_sentence_min)
         bump(T_MEDIUM_SENTENCES);
      else
         bump(T_LONG_SENTENCES);
      sent_words = '0;
   endtask

   function automatic logic [OUT_COUNT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
      if (64'(c) > 64'(OUT_COUNT_MAX))
         return OUT_COUNT_MAX;
      return OUT_COUNT_W'(c);
   endfunction

   // Advance the statistics by one text byte; queue the result on the last byte
   task automatic tally_byte(input req_type item);
      logic [BYTE_W-1:0] b;
      logic              is_term;
      logic              is_alnum;
      logic              was_pending;
      longint unsigned   quot;
      rsp_type           stats;
      b = item.text_byte;
      is_term = (b == CH_PERIOD) || (b == CH_QUESTION) || (b == CH_BANG);
      is_alnum = (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) ||
                 (b >= CH_UPPER_LO && b <= CH_UPPER_HI) ||
                 (b >= CH_LOWER_LO && b <= CH_LOWER_HI);
      // resolve a terminator from the previous byte first
      was_pending = term_pending;
      term_pending = 1'b0;
      if (was_pending && (b == CH_SPACE || b == CH_QUOTE))
         close_sentence();
      if ((is_term || b == CH_SPACE) && word_len != '0)
         close_word();
      else if (is_alnum && word_len != WORD_LEN_MAX)
         word_len = word_len + 1'b1;
      if (is_term) begin
         if (item.end_of_text)
            close_sentence();
         else
            term_pending = 1'b1;
      end
      if (item.end_of_text) begin
         stats.word_total            = clip_count(tallies[T_WORDS]);
         stats.short_word_total      = clip_count(tallies[T_SHORT_WORDS]);
         stats.medium_word_total     = clip_count(tallies[T_MEDIUM_WORDS]);
         stats.long_word_total       = clip_count(tallies[T_LONG_WORDS]);
         stats.sentence_total        = clip_count(tallies[T_SENTENCES]);
         stats.short_sentence_total  = clip_count(tallies[T_SHORT_SENTENCES]);
         stats.medium_sentence_total = clip_count(tallies[T_MEDIUM_SENTENCES]);
         stats.long_sentence_total   = clip_count(tallies[T_LONG_SENTENCES]);
         if (tallies[T_WORDS] == '0) begin
            stats.sentence_word_ratio = '0;
            stats.ratio_invalid = 1'b1;
         end else begin
            quot = (64'(tallies[T_SENTENCES]) << FRAC_BITS) / 64'(tallies[T_WORDS]);
            stats.sentence_word_ratio = (quot > 64'(RATIO_MAX)) ? RATIO_MAX : RATIO_W'(quot);
            stats.ratio_invalid = 1'b0;
         end
         text_stats_q = {text_stats_q, stats};
         clear_text();
      end
   endtask

   // Follow register writes and transfers on both channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limits.short_word_max = RST_SHORT_WORD_MAX;
         limits.long_word_min = RST_LONG_WORD_MIN;
         limits.short_sentence_below = RST_SHORT_SENTENCE_BELOW;
         limits.long_sentence_min = RST_LONG_SENTENCE_MIN;
         clear_text();
         text_stats_q.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SHORT_WORD_MAX:       limits.short_word_max = csr_wdata[WORD_LEN_W-1:0];
               CSR_LONG_WORD_MIN:        limits.long_word_min = csr_wdata[WORD_LEN_W-1:0];
               CSR_SHORT_SENTENCE_BELOW: limits.short_sentence_below = csr_wdata;
               CSR_LONG_SENTENCE_MIN:    limits.long_sentence_min = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            tally_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (text_stats_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected",
                               rsp_data.word_total, 0);
            end else begin
               want = text_stats_q.pop_front();
               check_field("word_total", rsp_data.word_total, want.word_total);
               check_field("short_word_total", rsp_data.short_word_total,
                           want.short_word_total);
               check_field("medium_word_total", rsp_data.medium_word_total,
                           want.medium_word_total);
               check_field("long_word_total", rsp_data.long_word_total,
                           want.long_word_total);
               check_field("sentence_total", rsp_data.sentence_total, want.sentence_total);
               check_field("short_sentence_total", rsp_data.short_sentence_total,
                           want.short_sentence_total);
               check_field("medium_sentence_total", rsp_data.medium_sentence_total,
                           want.medium_sentence_total);
               check_field("long_sentence_total", rsp_data.long_sentence_total,
                           want.long_sentence_total);
               check_field("sentence_word_ratio", rsp_data.sentence_word_ratio,
                           want.sentence_word_ratio);
               check_field("ratio_invalid", rsp_data.ratio_invalid, want.ratio_invalid);
            end
         end
      end
      results_pending <= text_stats_q.size();
   end

endmodule

// ===== tb/text_word_sentence_stats_top_test.sv =====
// Testbench top for the text statistics block: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module text_word_sentence_stats_top_test;
   import sws_pkg::*;

   localparam int CLEAR_WAIT  = 60;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLDOFF     = 400;
   localparam logic [BYTE_W-1:0] EDGE_CHARS [12] = '{8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40,
      8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'h2C, 8'h0A};

   typedef logic [BYTE_W-1:0] text_bytes_type [$];

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_data;
   logic                    csr_we;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   int                      mismatches;
   int                      results_pending;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   int                      holdoff_requests = 0;

   text_word_sentence_stats_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   text_stats_checker u_stats_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive result stall: random per cycle, or a long hold-off on request
   initial begin : rsp_stall_gen
      int holdoff_left;
      int holdoff_served;
      holdoff_left = 0;
      holdoff_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_served != holdoff_requests) begin
            holdoff_served = holdoff_requests;
            holdoff_left = HOLDOFF;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // End the run when no transfer or write happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] alnum_char();
      case ($urandom_range(2))
         0:       return CH_DIGIT_LO + BYTE_W'($urandom_range(9));
         1:       return CH_UPPER_LO + BYTE_W'($urandom_range(25));
         default: return CH_LOWER_LO + BYTE_W'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] noise_char();
      if ($urandom_range(1) == 0)
         return EDGE_CHARS[$urandom_range(11)];
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [BYTE_W-1:0] term_char();
      case ($urandom_range(2))
         0:       return CH_PERIOD;
         1:       return CH_QUESTION;
         default: return CH_BANG;
      endcase
   endfunction

   task automatic append_byte(inout text_bytes_type txt, input logic [BYTE_W-1:0] b);
      txt = {txt, b};
   endtask

   task automatic append_string(inout text_bytes_type txt, input string s);
      for (int i = 0; i < s.len(); i++)
         append_byte(txt, s[i]);
   endtask

   task automatic append_word(inout text_bytes_type txt);
      int len;
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      repeat (len) begin
         append_byte(txt, alnum_char());
         if ($urandom_range(29) == 0)
            append_byte(txt, noise_char());
      end
   endtask

   // Build one text: mostly sentences of words, some noise and broken texts
   task automatic compose_text(output text_bytes_type txt);
      int kind;
      int n_words;
      txt = {};
      kind = $urandom_range(99);
      if (kind < 6) begin
         append_byte(txt, noise_char());
      end else if (kind < 14) begin
         repeat ($urandom_range(1, 12))
            append_byte(txt, noise_char());
      end else begin
         repeat ($urandom_range(0, 3)) begin
            n_words = ($urandom_range(7) == 0) ? $urandom_range(12, 26) : $urandom_range(0, 5);
            for (int w = 0; w < n_words; w++) begin
               append_word(txt);
               // the last word may run straight into its terminator
               if (w != n_words - 1 || $urandom_range(1) == 0) begin
                  append_byte(txt, CH_SPACE);
                  if ($urandom_range(7) == 0)
                     append_byte(txt, CH_SPACE);
               end
            end
            append_byte(txt, term_char());
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: append_byte(txt, CH_SPACE);
               6, 7:             append_byte(txt, CH_QUOTE);
               8:                append_byte(txt, alnum_char());
               default:          append_byte(txt, noise_char());
            endcase
         end
         // trailing words with no terminator
         repeat ($urandom_range(0, 2)) begin
            append_word(txt);
            append_byte(txt, CH_SPACE);
         end
         case ($urandom_range(3))
            0:       append_byte(txt, term_char());
            1:       append_byte(txt, alnum_char());
            2:       append_byte(txt, CH_SPACE);
            default: append_byte(txt, noise_char());
         endcase
      end
   endtask

   task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{text_byte: b, end_of_text: last};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_text(input text_bytes_type txt);
      foreach (txt[i])
         put_byte(txt[i], i == txt.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_bytes_type txt;
      txt = {};
      append_string(txt, s);
      send_text(txt);
   endtask

   // Hold the sender until every result is back, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
      repeat (CLEAR_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Word limits are 6 bits wide; the upper data bits get random values
   task automatic set_limits(input int swm, input int lwm, input int ssb, input int lsm);
      settle();
      write_reg(CSR_SHORT_WORD_MAX, {2'($urandom_range(3)), 6'(swm)});
      write_reg(CSR_LONG_WORD_MIN, {2'($urandom_range(3)), 6'(lwm)});
      write_reg(CSR_SHORT_SENTENCE_BELOW, 8'(ssb));
      write_reg(CSR_LONG_SENTENCE_MIN, 8'(lsm));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_random_limits();
      set_limits($urandom_range(1, 62), $urandom_range(2, 63),
                 $urandom_range(1, 254), $urandom_range(2, 255));
   endtask

   task automatic run_phase(input int byte_budget, input int send_pct, input int recv_pct,
                            input bit hold_receiver);
      text_bytes_type txt;
      int sent;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      if (hold_receiver)
         holdoff_requests++;
      while (sent < byte_budget) begin
         compose_text(txt);
         send_text(txt);
         sent += txt.size();
         if ($urandom_range(14) == 0)
            settle();
      end
   endtask

   initial begin : stimulus
      text_bytes_type txt;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_SHORT_WORD_MAX;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts under reset limits
      txt = {};
      append_byte(txt, 8'h00);
      send_text(txt);                  // no words at all
      send_string("Ab1 x?\"Q.");       // quote after terminator, terminator on last byte
      txt = {};
      append_string(txt, "go.on! ");   // terminator followed by a letter is no sentence end
      append_byte(txt, 8'hFF);
      append_byte(txt, CH_LOWER_LO + 8'd22);
      send_text(txt);                  // unfinished word at the end
      send_string(". !");              // sentences without words

      // Extreme and inverted limits across the idling phases
      set_limits(1, 2, 1, 2);
      run_phase(50, 0, 0, 1'b0);
      set_limits(62, 63, 254, 255);
      run_phase(80, 88, 0, 1'b0);
      set_limits(62, 2, 200, 3);
      run_phase(80, 0, 88, 1'b0);
      set_random_limits();
      run_phase(90, 6, 6, 1'b0);

      // Receiver holds off while the sender keeps offering
      set_random_limits();
      run_phase(150, 0, 0, 1'b1);

      // Saturation: long word, ratio above its range
      set_limits(3, 8, 1, 255);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      txt = {};
      repeat (70) append_byte(txt, CH_UPPER_LO);
      append_string(txt, " ok.");
      send_text(txt);
      txt = {};
      append_byte(txt, CH_LOWER_LO);
      repeat (257) append_string(txt, ". ");
      append_byte(txt, CH_BANG);
      send_text(txt);

      set_random_limits();
      run_phase(70, 6, 6, 1'b0);

      settle();
      if (mismatches == 0 && results_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== text_word_sentence_stats_top.f =====
hw/rtl/sws_pkg.sv
hw/rtl/sws_front.sv
hw/rtl/sws_div.sv
hw/rtl/sws_back.sv
hw/rtl/text_word_sentence_stats_top.sv
hw/rtl/sws_check.sv
tb/text_stats_checker.sv
tb/text_word_sentence_stats_top_test.sv
